### hw/rtl/mpfl_pkg.sv
// Shared widths, item codes and status codes of the multi-pool free-list allocator.
package mpfl_pkg;

  localparam int unsigned POOLS_DEF       = 4;
  localparam int unsigned HEAP_BYTES_DEF  = 4096;
  localparam int unsigned ALIGN_BYTES_DEF = 8;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POOL_W   = 4;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BLOCK_W  = 12;

  localparam int unsigned RSIZE_W  = SIZE_W + 1;
  localparam int unsigned BYTES_W  = RSIZE_W + COUNT_W;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_ALLOC = 2'd0;
  localparam kind_t KIND_FREE  = 2'd1;
  localparam kind_t KIND_INIT  = 2'd2;
  localparam kind_t KIND_NOP   = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_BADPOOL = 2'd2;
  localparam status_t ST_NOHEAP  = 2'd3;

endpackage

### hw/rtl/mpfl_alu.sv
// Shared adder and subtractor used by the allocator sequencer.
module mpfl_alu #(
  parameter int unsigned W = 24
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W:0]   res
);

  logic [W-1:0] b_eff;

  assign b_eff = b ^ {W{sub}};
  assign res   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

### hw/rtl/multi_pool_free_list_allocator.sv
// Top level of the multi-pool free-list allocator with sequencer and link memory.
//
// An item is transferred when start is high and busy is low. Its fields are
// in_kind, in_pool, in_block_addr, in_block_size and in_block_count. Each item
// gives exactly one result: out_status and out_block_out, shown for one cycle
// with out_valid high. The receiver cannot stall; every result is taken.
// A bad pool number or an unused kind is answered in the cycle after the
// transfer without raising busy. For allocate and free, the transfer edge
// reads the head's next link from the link memory, and the following cycle
// updates the head and registers the result, which appears while the next
// item may already be transferred.
// Initialise rounds the size on the shared adder, multiplies, and checks the
// heap, ending there on failure; on success it then makes one push a cycle
// through the single write port of the link memory, with the shared adder
// stepping the block address.
// Reset empties every pool and restores the heap top; the link memory is not
// cleared and needs no clearing pass.
module multi_pool_free_list_allocator #(
  parameter int unsigned POOLS       = mpfl_pkg::POOLS_DEF,
  parameter int unsigned HEAP_BYTES  = mpfl_pkg::HEAP_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES = mpfl_pkg::ALIGN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mpfl_pkg::KIND_W-1:0]    in_kind,
  input  logic [mpfl_pkg::POOL_W-1:0]    in_pool,
  input  logic [mpfl_pkg::ADDR_W-1:0]    in_block_addr,
  input  logic [mpfl_pkg::SIZE_W-1:0]    in_block_size,
  input  logic [mpfl_pkg::COUNT_W-1:0]   in_block_count,
  output logic                           out_valid,
  output logic [mpfl_pkg::STATUS_W-1:0]  out_status,
  output logic [mpfl_pkg::BLOCK_W-1:0]   out_block_out
);

  localparam int unsigned ALIGN_LG = $clog2(ALIGN_BYTES);
  localparam int unsigned LINKS    = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned LINK_W   = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int unsigned TOP_W    = $clog2(HEAP_BYTES + 1);
  localparam int unsigned POOL_IW  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned HEAD_N   = 1 << POOL_IW;
  localparam int unsigned ALU_W    =
    ((mpfl_pkg::BYTES_W > TOP_W) ? mpfl_pkg::BYTES_W : TOP_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_RND   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [ALU_W-1:0] align_mask;
  assign align_mask = ~ALU_W'(ALIGN_BYTES - 1);

  logic [2:0]                     state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  mpfl_pkg::status_t              out_status_r, out_status_nxt;
  logic [mpfl_pkg::BLOCK_W-1:0]   out_block_r, out_block_nxt;
  logic [TOP_W-1:0]               heap_top_r, heap_top_nxt;
  logic [TOP_W-1:0]               addr_r, addr_nxt;
  logic [mpfl_pkg::RSIZE_W-1:0]   rsize_r, rsize_nxt;
  logic [mpfl_pkg::BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [mpfl_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;

  logic [POOL_IW-1:0]             pool_r;
  logic [mpfl_pkg::ADDR_W-1:0]    free_addr_r;
  logic [mpfl_pkg::SIZE_W-1:0]    size_r;
  logic [mpfl_pkg::COUNT_W-1:0]   count_r;

  logic                           head_vld_r [HEAD_N];
  logic [LINK_W-1:0]              head_idx_r [HEAD_N];
  logic                           head_we;
  logic                           head_wr_vld;
  logic [LINK_W-1:0]              head_wr_idx;

  logic [LINK_W:0]                link_mem [LINKS];
  logic [LINK_W:0]                rd_q;
  logic [LINK_W-1:0]              rd_addr;
  logic                           mem_we;
  logic [LINK_W-1:0]              mem_wa;
  logic [LINK_W:0]                mem_wd;

  logic [ALU_W-1:0]               alu_a, alu_b;
  logic                           alu_sub;
  logic [ALU_W:0]                 alu_res;

  logic                           accept;
  logic                           in_bad;
  logic                           cur_vld;
  logic [LINK_W-1:0]              cur_idx;
  logic [LINK_W-1:0]              free_slot;
  logic [LINK_W-1:0]              push_slot;
  logic [LINK_W+ALIGN_LG-1:0]     blk_full;
  logic [ALU_W-1:0]               aligned;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_bad    = (in_kind != mpfl_pkg::KIND_NOP) && (5'(in_pool) >= 5'(POOLS));
  assign rd_addr   = head_idx_r[in_pool[POOL_IW-1:0]];
  assign cur_vld   = head_vld_r[pool_r];
  assign cur_idx   = head_idx_r[pool_r];
  assign free_slot = LINK_W'(free_addr_r >> ALIGN_LG);
  assign push_slot = LINK_W'(addr_r >> ALIGN_LG);
  assign blk_full  = {cur_idx, {ALIGN_LG{1'b0}}};
  assign aligned   = alu_res[ALU_W-1:0] & align_mask;
  assign cnt_inc   = cnt_r + 1'b1;

  mpfl_alu #(
    .W (ALU_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  always_comb begin
    alu_a   = ALU_W'(addr_r);
    alu_b   = ALU_W'(rsize_r);
    alu_sub = 1'b0;
    case (state_r)
      S_RND: begin
        alu_a = ALU_W'(size_r);
        alu_b = ALU_W'(ALIGN_BYTES - 1);
      end
      S_CHK: begin
        alu_a   = ALU_W'(heap_top_r);
        alu_b   = ALU_W'(bytes_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = ALU_W'(addr_r);
        alu_b = ALU_W'(rsize_r);
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    heap_top_nxt   = heap_top_r;
    addr_nxt       = addr_r;
    rsize_nxt      = rsize_r;
    bytes_nxt      = bytes_r;
    cnt_nxt        = cnt_r;
    head_we        = 1'b0;
    head_wr_vld    = 1'b0;
    head_wr_idx    = '0;
    mem_we         = 1'b0;
    mem_wa         = push_slot;
    mem_wd         = {cur_vld, cur_idx};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = mpfl_pkg::ST_BADPOOL;
            out_block_nxt  = '0;
          end else begin
            case (in_kind)
              mpfl_pkg::KIND_ALLOC: state_nxt = S_ALLOC;
              mpfl_pkg::KIND_FREE:  state_nxt = S_FREE;
              mpfl_pkg::KIND_INIT:  state_nxt = S_RND;
              default: begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = mpfl_pkg::ST_OK;
                out_block_nxt  = '0;
              end
            endcase
          end
        end
      end
      S_ALLOC: begin
        out_valid_nxt = 1'b1;
        if (!cur_vld) begin
          out_status_nxt = mpfl_pkg::ST_EMPTY;
          out_block_nxt  = '0;
        end else begin
          out_status_nxt = mpfl_pkg::ST_OK;
          out_block_nxt  = mpfl_pkg::BLOCK_W'(blk_full);
          head_we        = 1'b1;
          head_wr_vld    = rd_q[LINK_W];
          head_wr_idx    = rd_q[LINK_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      S_FREE: begin
        mem_we         = 1'b1;
        mem_wa         = free_slot;
        head_we        = 1'b1;
        head_wr_vld    = 1'b1;
        head_wr_idx    = free_slot;
        out_valid_nxt  = 1'b1;
        out_status_nxt = mpfl_pkg::ST_OK;
        out_block_nxt  = '0;
        state_nxt      = S_IDLE;
      end
      S_RND: begin
        rsize_nxt = mpfl_pkg::RSIZE_W'(aligned);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        bytes_nxt = mpfl_pkg::BYTES_W'(rsize_r) * mpfl_pkg::BYTES_W'(count_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((bytes_r == '0) || !alu_res[ALU_W]) begin
          head_we        = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = mpfl_pkg::ST_NOHEAP;
          out_block_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          heap_top_nxt = TOP_W'(aligned);
          addr_nxt     = TOP_W'(aligned);
          cnt_nxt      = '0;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        mem_we      = 1'b1;
        mem_wa      = push_slot;
        head_we     = 1'b1;
        head_wr_vld = 1'b1;
        head_wr_idx = push_slot;
        addr_nxt    = TOP_W'(alu_res[ALU_W-1:0]);
        cnt_nxt     = cnt_inc;
        if (cnt_inc == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = mpfl_pkg::ST_OK;
          out_block_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      heap_top_r  <= TOP_W'(HEAP_BYTES);
      for (int i = 0; i < HEAD_N; i++) begin
        head_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      heap_top_r  <= heap_top_nxt;
      if (head_we) begin
        head_vld_r[pool_r] <= head_wr_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    addr_r       <= addr_nxt;
    rsize_r      <= rsize_nxt;
    bytes_r      <= bytes_nxt;
    cnt_r        <= cnt_nxt;
    if (head_we) begin
      head_idx_r[pool_r] <= head_wr_idx;
    end
    if (accept) begin
      pool_r      <= in_pool[POOL_IW-1:0];
      free_addr_r <= in_block_addr;
      size_r      <= in_block_size;
      count_r     <= in_block_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_q <= link_mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_block_out = out_block_r;

  a_bad_pool: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_bad |=> out_valid && (out_status == mpfl_pkg::ST_BADPOOL))
    else $error("bad pool transfer not answered with bad pool status");

  a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mpfl_pkg::ST_OK) |-> (out_block_out == '0))
    else $error("block offset given with a failing status");

  a_heap_down: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> heap_top_r <= $past(heap_top_r))
    else $error("heap top moved upward");

  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !out_valid_nxt)
    else $error("result raised in the middle of an initialise");

endmodule
